### hdl/cbclip_pkg.sv
`default_nettype none

package cbclip_pkg;

    // Coordinates are signed fixed point; the fraction bits cancel in N/D.
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DET_W   = PROD_W + 1;
    localparam int MAG_W   = DET_W;
    localparam int REM_W   = MAG_W + 1;

    // Parametric t is signed Q2.16, saturated to +/-2.0.
    localparam int T_FRAC = 16;
    localparam int Q_W    = T_FRAC + 2;
    localparam int T_W    = Q_W + 1;

    localparam logic signed [T_W-1:0] T_ONE = T_W'(2 ** T_FRAC);
    localparam logic [Q_W-1:0]        Q_SAT = Q_W'(2 ** (T_FRAC + 1));

    // Divider steps: saturation check, integer bit, then one fraction bit per step.
    localparam int DIV_LAST = T_FRAC + 1;
    localparam int STEP_W   = $clog2(DIV_LAST + 1);
    localparam logic [STEP_W-1:0] DIV_SAT_STEP = STEP_W'(0);
    localparam logic [STEP_W-1:0] DIV_INT_STEP = STEP_W'(1);
    localparam logic [STEP_W-1:0] DIV_END_STEP = STEP_W'(DIV_LAST);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DET,
        S_DIV,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        P_MUL0,
        P_MUL1,
        P_MUL2,
        P_MUL3,
        P_FIN
    } t_det_phase;

endpackage

`default_nettype wire

### hdl/segment_convex_polygon_clip_test.sv
// o_stall is high while an edge works: a full quotient runs the multiplier and all divider
// steps, a saturating one ends at the saturation check, a parallel edge skips the divider,
// and an edge after the segment is known clear skips all arithmetic. A last edge then loads
// the verdict, waiting while the result register is full and stalled. Throughput is set by
// the serial multiplier and the one-bit-per-cycle divider. A synchronous active-low reset
// zeroes the held segment, sets the bounds to 0.0 .. 1.0, clears the verdict and the output.
`default_nettype none

module segment_convex_polygon_clip_test (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [cbclip_pkg::COORD_W-1:0] i_seg_start_x,
    input  logic signed [cbclip_pkg::COORD_W-1:0] i_seg_start_y,
    input  logic signed [cbclip_pkg::COORD_W-1:0] i_seg_end_x,
    input  logic signed [cbclip_pkg::COORD_W-1:0] i_seg_end_y,
    input  logic signed [cbclip_pkg::COORD_W-1:0] i_edge_from_x,
    input  logic signed [cbclip_pkg::COORD_W-1:0] i_edge_from_y,
    input  logic signed [cbclip_pkg::COORD_W-1:0] i_edge_to_x,
    input  logic signed [cbclip_pkg::COORD_W-1:0] i_edge_to_y,
    input  logic                                  i_first_edge,
    input  logic                                  i_last_edge,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_segment_clear
);
    import cbclip_pkg::*;

    // Sequencer state and per-query state.
    t_state                    r_state;
    t_state                    n_state;
    logic signed [COORD_W-1:0] r_held_start_x;
    logic signed [COORD_W-1:0] r_held_start_y;
    logic signed [COORD_W-1:0] r_held_end_x;
    logic signed [COORD_W-1:0] r_held_end_y;
    logic signed [T_W-1:0]     r_enter;
    logic signed [T_W-1:0]     r_leave;
    logic                      r_found_clear;
    logic                      r_last;

    // Difference vectors of the current edge, captured with the beat.
    logic signed [DIFF_W-1:0] r_ex;
    logic signed [DIFF_W-1:0] r_ey;
    logic signed [DIFF_W-1:0] r_wx;
    logic signed [DIFF_W-1:0] r_wy;
    logic signed [DIFF_W-1:0] r_sx;
    logic signed [DIFF_W-1:0] r_sy;

    // Result register, which frees the sequencer from the output side.
    logic r_out_valid;
    logic r_out_clear;

    logic                      accept;
    logic                      out_free;
    logic                      clear_eff;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      det_start;
    logic                      div_start;
    logic                      det_done;
    logic                      div_done;
    logic signed [DET_W-1:0]   num;
    logic signed [DET_W-1:0]   den;
    logic signed [T_W-1:0]     t_val;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // A first edge starts a fresh query, so it sees its own segment and no
    // earlier verdict; other edges keep working with the held segment.
    always_comb begin
        start_x   = i_first_edge ? i_seg_start_x : r_held_start_x;
        start_y   = i_first_edge ? i_seg_start_y : r_held_start_y;
        end_x     = i_first_edge ? i_seg_end_x   : r_held_end_x;
        end_y     = i_first_edge ? i_seg_end_y   : r_held_end_y;
        clear_eff = !i_first_edge && r_found_clear;
    end

    // N = det(E, W) and D = -det(E, S) come out of the shared multiplier.
    cbclip_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (det_start),
        .i_ex    (r_ex),
        .i_ey    (r_ey),
        .i_wx    (r_wx),
        .i_wy    (r_wy),
        .i_sx    (r_sx),
        .i_sy    (r_sy),
        .o_done  (det_done),
        .o_num   (num),
        .o_den   (den)
    );

    // t = N / D in Q2.16, truncated toward zero and saturated to +/-2.0.
    cbclip_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_t     (t_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An edge that arrives after the verdict is already clear skips all
    // arithmetic. A parallel edge (D of zero) skips the divider.
    always_comb begin
        n_state   = r_state;
        det_start = 1'b0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (clear_eff) begin
                        n_state = i_last_edge ? S_EMIT : S_IDLE;
                    end else begin
                        det_start = 1'b1;
                        n_state   = S_DET;
                    end
                end
            end
            S_DET: begin
                if (det_done) begin
                    if (den == '0) begin
                        n_state = r_last ? S_EMIT : S_IDLE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Query state. A negative D makes t an entering bound that can only
    // rise; a positive D makes it a leaving bound that can only fall. The
    // segment is clear once the bounds cross, or when a parallel edge sees a negative N.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_start_x <= '0;
            r_held_start_y <= '0;
            r_held_end_x   <= '0;
            r_held_end_y   <= '0;
            r_enter        <= '0;
            r_leave        <= T_ONE;
            r_found_clear  <= 1'b0;
            r_last         <= 1'b0;
        end else begin
            if (accept) begin
                r_last <= i_last_edge;
                if (i_first_edge) begin
                    r_held_start_x <= i_seg_start_x;
                    r_held_start_y <= i_seg_start_y;
                    r_held_end_x   <= i_seg_end_x;
                    r_held_end_y   <= i_seg_end_y;
                    r_enter        <= '0;
                    r_leave        <= T_ONE;
                    r_found_clear  <= 1'b0;
                end
            end
            if ((r_state == S_DET) && det_done && (den == '0) && num[DET_W-1]) begin
                r_found_clear <= 1'b1;
            end
            if ((r_state == S_DIV) && div_done) begin
                if (den[DET_W-1]) begin
                    if (t_val > r_enter) begin
                        r_enter <= t_val;
                        if (t_val > r_leave) begin
                            r_found_clear <= 1'b1;
                        end
                    end
                end else begin
                    if (t_val < r_leave) begin
                        r_leave <= t_val;
                        if (t_val < r_enter) begin
                            r_found_clear <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    // The vectors E = to - from, W = start - from and S = end - start.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ex <= DIFF_W'(i_edge_to_x) - DIFF_W'(i_edge_from_x);
            r_ey <= DIFF_W'(i_edge_to_y) - DIFF_W'(i_edge_from_y);
            r_wx <= DIFF_W'(start_x) - DIFF_W'(i_edge_from_x);
            r_wy <= DIFF_W'(start_y) - DIFF_W'(i_edge_from_y);
            r_sx <= DIFF_W'(end_x) - DIFF_W'(start_x);
            r_sy <= DIFF_W'(end_y) - DIFF_W'(start_y);
        end
    end

    // The verdict beat is loaded when the result register is empty or is
    // being emptied in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_out_clear <= r_found_clear;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_segment_clear = r_out_clear;

`ifndef SYNTHESIS
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_found_clear |-> (r_enter <= r_leave))
        else $error("bounds crossed without a clear verdict");

    a_enter_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enter[T_W-1])
        else $error("entering bound fell below zero");

    a_leave_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_leave <= T_ONE)
        else $error("leaving bound rose above one");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && !i_stall) |=> o_valid)
        else $error("verdict beat was not loaded");
`endif

endmodule

`default_nettype wire

### hdl/cbclip_det.sv
`default_nettype none

module cbclip_det (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [cbclip_pkg::DIFF_W-1:0] i_ex,
    input  logic signed [cbclip_pkg::DIFF_W-1:0] i_ey,
    input  logic signed [cbclip_pkg::DIFF_W-1:0] i_wx,
    input  logic signed [cbclip_pkg::DIFF_W-1:0] i_wy,
    input  logic signed [cbclip_pkg::DIFF_W-1:0] i_sx,
    input  logic signed [cbclip_pkg::DIFF_W-1:0] i_sy,
    output logic                                 o_done,
    output logic signed [cbclip_pkg::DET_W-1:0]  o_num,
    output logic signed [cbclip_pkg::DET_W-1:0]  o_den
);
    import cbclip_pkg::*;

    logic                     r_busy;
    logic                     r_done;
    t_det_phase               r_phase;
    logic signed [PROD_W-1:0] r_p;
    logic signed [DET_W-1:0]  r_num;
    logic signed [DET_W-1:0]  r_den;

    logic signed [DIFF_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [DET_W-1:0]  acc_a;
    logic signed [DET_W-1:0]  acc;

    // One multiplier walks the four cross products; the subtractor folds
    // each pair into a determinant once its second product is registered.
    always_comb begin
        case (r_phase)
            P_MUL0: begin
                mul_a = i_ex;
                mul_b = i_wy;
            end
            P_MUL1: begin
                mul_a = i_ey;
                mul_b = i_wx;
            end
            P_MUL2: begin
                mul_a = i_ey;
                mul_b = i_sx;
            end
            P_MUL3: begin
                mul_a = i_ex;
                mul_b = i_sy;
            end
            default: begin
                mul_a = i_ex;
                mul_b = i_wy;
            end
        endcase
        prod  = mul_a * mul_b;
        acc_a = (r_phase == P_MUL2) ? r_num : r_den;
        acc   = acc_a - DET_W'(r_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= P_MUL0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= P_MUL0;
            end else if (r_busy) begin
                case (r_phase)
                    P_MUL0:  r_phase <= P_MUL1;
                    P_MUL1:  r_phase <= P_MUL2;
                    P_MUL2:  r_phase <= P_MUL3;
                    P_MUL3:  r_phase <= P_FIN;
                    default: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_p <= prod;
            case (r_phase)
                P_MUL1:  r_num <= DET_W'(r_p);
                P_MUL2:  r_num <= acc;
                P_MUL3:  r_den <= DET_W'(r_p);
                P_FIN:   r_den <= acc;
                default: ;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_num  = r_num;
    assign o_den  = r_den;

endmodule

`default_nettype wire

### hdl/cbclip_div.sv
`default_nettype none

module cbclip_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [cbclip_pkg::DET_W-1:0] i_num,
    input  logic signed [cbclip_pkg::DET_W-1:0] i_den,
    output logic                                o_done,
    output logic signed [cbclip_pkg::T_W-1:0]   o_t
);
    import cbclip_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [REM_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_div;
    logic [Q_W-1:0]    r_q;
    logic              r_neg;

    logic [MAG_W-1:0]     num_mag;
    logic [MAG_W-1:0]     den_mag;
    logic [REM_W-1:0]     sub_a;
    logic [REM_W-1:0]     sub_b;
    logic [REM_W:0]       diff;
    logic                 ge;
    logic signed [T_W-1:0] t_pos;

    // Restoring division on magnitudes with one shared subtractor. The
    // first step compares against twice the divisor to catch saturation.
    always_comb begin
        num_mag = i_num[DET_W-1] ? MAG_W'(-i_num) : MAG_W'(i_num);
        den_mag = i_den[DET_W-1] ? MAG_W'(-i_den) : MAG_W'(i_den);
        sub_a   = (r_step > DIV_INT_STEP) ? {r_rem[REM_W-2:0], 1'b0} : r_rem;
        sub_b   = (r_step == DIV_SAT_STEP) ? {r_div, 1'b0} : {1'b0, r_div};
        diff    = {1'b0, sub_a} - {1'b0, sub_b};
        ge      = ~diff[REM_W];
        t_pos   = {1'b0, r_q};
        o_t     = r_neg ? -t_pos : t_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= DIV_SAT_STEP;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= DIV_SAT_STEP;
            end else if (r_busy) begin
                if ((r_step == DIV_END_STEP) || ((r_step == DIV_SAT_STEP) && ge)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, num_mag};
            r_div <= den_mag;
            r_neg <= i_num[DET_W-1] ^ i_den[DET_W-1];
            r_q   <= '0;
        end else if (r_busy) begin
            case (r_step)
                DIV_SAT_STEP: begin
                    if (ge) begin
                        r_q <= Q_SAT;
                    end
                end
                DIV_INT_STEP: begin
                    if (ge) begin
                        r_rem <= diff[REM_W-1:0];
                    end
                    r_q <= {{(Q_W-1){1'b0}}, ge};
                end
                default: begin
                    r_rem <= ge ? diff[REM_W-1:0] : sub_a;
                    r_q   <= {r_q[Q_W-2:0], ge};
                end
            endcase
        end
    end

    assign o_done = r_done;

`ifndef SYNTHESIS
    a_sat_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && (r_step == DIV_SAT_STEP) && ge)
        |=> (r_done && (r_q == Q_SAT)))
        else $error("saturating quotient did not finish at once");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= DIV_END_STEP))
        else $error("divider step ran past the last fraction bit");
`endif

endmodule

`default_nettype wire

### verif/segment_convex_polygon_clip_test_test.sv
`timescale 1ns / 100ps

module segment_convex_polygon_clip_test_test;
    import cbclip_pkg::*;

    // Coordinates are signed Q4.12 at the block's width; 1.0 is 4096.
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam int COORD_HI = 2 ** (COORD_W - 1) - 1;
    localparam int COORD_LO = -(2 ** (COORD_W - 1));
    localparam coord_t UNIT         = coord_t'(4096);
    localparam coord_t HALF_UNIT    = coord_t'(2048);
    localparam coord_t QUARTER_UNIT = coord_t'(1024);

    // Run shape. The random part stops at RANDOM_END beats, the full-speed
    // stream at the end brings the total to about STREAM_END beats.
    localparam int RANDOM_END     = 1320;
    localparam int STREAM_END     = 1550;
    localparam int HOLD_BEATS     = 12;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 64;
    // The limit sits far above the cost of a quotient edge plus the longest
    // sender gap and receiver stall, and far above the long hold-off.
    localparam int WATCHDOG_LIMIT = 5000;

    // Cosines of twelve directions 30 degrees apart, scaled by 1024. The sine
    // of direction i is the cosine of direction (i + 9) mod 12.
    localparam int RING_COS[12] = '{1024, 887, 512, 0, -512, -887,
                                    -1024, -887, -512, 0, 512, 887};

    // One input beat: a polygon edge plus the segment, which the block only
    // takes when first_edge is set.
    typedef struct {
        coord_t seg_x0, seg_y0, seg_x1, seg_y1;
        coord_t from_x, from_y, to_x, to_y;
        bit     first_edge, last_edge;
    } edge_beat_t;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    coord_t i_seg_start_x, i_seg_start_y, i_seg_end_x, i_seg_end_y;
    coord_t i_edge_from_x, i_edge_from_y, i_edge_to_x, i_edge_to_y;
    logic   i_first_edge;
    logic   i_last_edge;
    logic   o_valid;
    logic   i_stall;
    logic   o_segment_clear;

    segment_convex_polygon_clip_test dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_seg_start_x   (i_seg_start_x),
        .i_seg_start_y   (i_seg_start_y),
        .i_seg_end_x     (i_seg_end_x),
        .i_seg_end_y     (i_seg_end_y),
        .i_edge_from_x   (i_edge_from_x),
        .i_edge_from_y   (i_edge_from_y),
        .i_edge_to_x     (i_edge_to_x),
        .i_edge_to_y     (i_edge_to_y),
        .i_first_edge    (i_first_edge),
        .i_last_edge     (i_last_edge),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_segment_clear (o_segment_clear)
    );

    // Verdicts the block still owes, oldest first.
    bit verdicts_due[$];

    // Our own copy of the clipper state: the held segment, the entering and
    // leaving bounds of t in Q2.16, and whether the segment is known clear.
    coord_t held_x0, held_y0, held_x1, held_y1;
    int     t_enter, t_leave;
    bit     seg_clear;

    int error_count = 0;
    int beats_sent  = 0;
    int idle_cycles = 0;

    // Idling switches. The sender's switch is read by the send task, the
    // receiver's by its own process. A hold request is picked up by the
    // receiver, which then counts the long hold-off itself.
    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Advance the predicted clipper by one accepted edge. Differences and
    // products are exact in 64 bits (N and D need at most 35). The quotient
    // is truncated toward zero and saturates to 2.0 when |N| >= 2|D|.
    function automatic void clip_edge(input edge_beat_t b);
        longint ex, ey, wx, wy, sx, sy;
        longint num, den, nmag, dmag, tmag;
        int     t;
        if (b.first_edge) begin
            held_x0   = b.seg_x0;
            held_y0   = b.seg_y0;
            held_x1   = b.seg_x1;
            held_y1   = b.seg_y1;
            t_enter   = 0;
            t_leave   = int'(T_ONE);
            seg_clear = 1'b0;
        end
        // Once the segment is known clear, the rest of the polygon is ignored.
        if (!seg_clear) begin
            ex  = longint'(b.to_x) - longint'(b.from_x);
            ey  = longint'(b.to_y) - longint'(b.from_y);
            wx  = longint'(held_x0) - longint'(b.from_x);
            wy  = longint'(held_y0) - longint'(b.from_y);
            sx  = longint'(held_x1) - longint'(held_x0);
            sy  = longint'(held_y1) - longint'(held_y0);
            num = ex * wy - ey * wx;
            den = ey * sx - ex * sy;
            if (den == 0) begin
                // Parallel edge, or a degenerate segment or edge: the start
                // point alone decides, and only an outside start matters.
                if (num < 0) seg_clear = 1'b1;
            end else begin
                nmag = (num < 0) ? -num : num;
                dmag = (den < 0) ? -den : den;
                if (nmag >= 2 * dmag) tmag = longint'(Q_SAT);
                else tmag = (nmag << T_FRAC) / dmag;
                t = ((num < 0) != (den < 0)) ? -int'(tmag) : int'(tmag);
                if (den < 0) begin
                    if (t > t_enter) begin
                        t_enter = t;
                        if (t_enter > t_leave) seg_clear = 1'b1;
                    end
                end else if (t < t_leave) begin
                    t_leave = t;
                    if (t_leave < t_enter) seg_clear = 1'b1;
                end
            end
        end
        if (b.last_edge) verdicts_due.push_back(seg_clear);
    endfunction

    // Offer one beat, maybe after a short gap, and hold it until the block
    // takes it. Valid is only lowered for a gap, never in the step in which
    // it is raised again.
    task automatic send_beat(input edge_beat_t b);
        int gap;
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_seg_start_x <= b.seg_x0;
        i_seg_start_y <= b.seg_y0;
        i_seg_end_x   <= b.seg_x1;
        i_seg_end_y   <= b.seg_y1;
        i_edge_from_x <= b.from_x;
        i_edge_from_y <= b.from_y;
        i_edge_to_x   <= b.to_x;
        i_edge_to_y   <= b.to_y;
        i_first_edge  <= b.first_edge;
        i_last_edge   <= b.last_edge;
        do @(posedge i_clk); while (o_stall);
        clip_edge(b);
        beats_sent++;
    endtask

    function automatic edge_beat_t make_beat(input coord_t x0, y0, x1, y1,
                                             input coord_t fx, fy, tx, ty,
                                             input bit first_edge, last_edge);
        edge_beat_t b;
        b.seg_x0     = x0;
        b.seg_y0     = y0;
        b.seg_x1     = x1;
        b.seg_y1     = y1;
        b.from_x     = fx;
        b.from_y     = fy;
        b.to_x       = tx;
        b.to_y       = ty;
        b.first_edge = first_edge;
        b.last_edge  = last_edge;
        return b;
    endfunction

    // Every field fully random, so every bit of every field toggles.
    function automatic edge_beat_t random_beat();
        return make_beat(coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), coord_t'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // A point within two radii of a center, clamped to the coordinate range.
    function automatic coord_t near_point(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(0, 4 * spread)) - 2 * spread;
        if (v > COORD_HI) v = COORD_HI;
        else if (v < COORD_LO) v = COORD_LO;
        return coord_t'(v);
    endfunction

    function automatic coord_t ring_coord(input int center, input int radius,
                                          input int dir);
        return coord_t'(center + radius * RING_COS[dir] / 1024);
    endfunction

    // The unit square, counterclockwise, against one segment.
    task automatic send_unit_square(input coord_t x0, y0, x1, y1);
        send_beat(make_beat(x0, y0, x1, y1, 0, 0, UNIT, 0, 1'b1, 1'b0));
        send_beat(make_beat(x0, y0, x1, y1, UNIT, 0, UNIT, UNIT, 1'b0, 1'b0));
        send_beat(make_beat(x0, y0, x1, y1, UNIT, UNIT, 0, UNIT, 1'b0, 1'b0));
        send_beat(make_beat(x0, y0, x1, y1, 0, UNIT, 0, 0, 1'b0, 1'b1));
    endtask

    // A random convex polygon: some of the twelve ring directions around a
    // random center, walked in order. Mostly counterclockwise and well formed;
    // now and then clockwise, missing its start or end mark, or followed by
    // stray edges that keep adding to the finished query.
    task automatic send_random_polygon();
        int         mask, radius, lim, cx, cy, n, k;
        int         dirs[$];
        bit         clockwise;
        edge_beat_t b;
        do mask = $urandom_range(1, 4095); while ($countones(mask) < 3);
        for (k = 0; k < 12; k++) if (mask[k]) dirs.push_back(k);
        clockwise = ($urandom_range(0, 9) == 0);
        if (clockwise) dirs.reverse();
        n      = dirs.size();
        radius = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16000)
                                             : $urandom_range(4, 4000);
        lim    = COORD_HI - radius;
        cx     = int'($urandom_range(0, 2 * lim)) - lim;
        cy     = int'($urandom_range(0, 2 * lim)) - lim;

        b.seg_x0 = near_point(cx, radius);
        b.seg_y0 = near_point(cy, radius);
        b.seg_x1 = near_point(cx, radius);
        b.seg_y1 = near_point(cy, radius);
        case ($urandom_range(0, 19))
            0: begin
                // Zero-length segment.
                b.seg_x1 = b.seg_x0;
                b.seg_y1 = b.seg_y0;
            end
            1: begin
                // Segment ending on a vertex.
                b.seg_x1 = ring_coord(cx, radius, dirs[0]);
                b.seg_y1 = ring_coord(cy, radius, (dirs[0] + 9) % 12);
            end
            default: ;
        endcase

        for (k = 0; k < n; k++) begin
            b.from_x     = ring_coord(cx, radius, dirs[k]);
            b.from_y     = ring_coord(cy, radius, (dirs[k] + 9) % 12);
            b.to_x       = ring_coord(cx, radius, dirs[(k + 1) % n]);
            b.to_y       = ring_coord(cy, radius, (dirs[(k + 1) % n] + 9) % 12);
            b.first_edge = (k == 0) && ($urandom_range(0, 19) != 0);
            b.last_edge  = (k == n - 1) && ($urandom_range(0, 9) != 0);
            send_beat(b);
        end
        if ($urandom_range(0, 9) == 0) begin
            for (k = 0; k < $urandom_range(1, 3); k++) begin
                b            = random_beat();
                b.first_edge = 1'b0;
                send_beat(b);
            end
        end
    endtask

    // Right after reset the held segment is the zero segment with bounds
    // 0 .. 1. Both polygon edges here continue that query without a start
    // mark: the first is collinear with the origin and changes nothing, the
    // second sees the origin outside and makes it clear.
    task automatic test_edges_without_start();
        send_beat(make_beat(0, 0, 0, 0, -UNIT, 0, UNIT, 0, 1'b0, 1'b1));
        send_beat(make_beat(0, 0, 0, 0, -UNIT, UNIT, UNIT, UNIT, 1'b0, 1'b1));
    endtask

    // A segment through the square intersects; one left of it is found clear
    // only at the square's last edge.
    task automatic test_square_queries();
        send_unit_square(-HALF_UNIT, HALF_UNIT, UNIT + HALF_UNIT, HALF_UNIT);
        send_unit_square(-(UNIT + UNIT), 0, -UNIT, UNIT + UNIT);
    endtask

    // Single-edge queries, start and end mark on the same beat, with a
    // segment parallel to the edge: once inside, once outside.
    task automatic test_parallel_edges();
        send_beat(make_beat(0, QUARTER_UNIT, UNIT, QUARTER_UNIT, 0, 0, UNIT, 0,
                            1'b1, 1'b1));
        send_beat(make_beat(0, QUARTER_UNIT, UNIT, QUARTER_UNIT, UNIT, 0, 0, 0,
                            1'b1, 1'b1));
    endtask

    // A zero-length segment and a zero-length edge both give D = 0.
    task automatic test_degenerate_input();
        send_beat(make_beat(7, 7, 7, 7, 0, 0, UNIT, UNIT, 1'b1, 1'b1));
        send_beat(make_beat(0, 0, UNIT, UNIT, -5, 3, -5, 3, 1'b1, 1'b1));
    endtask

    // Corner coordinates of the whole range. The third beat pits a tiny
    // segment against a distant edge so that t saturates to 2.0. After it,
    // edges without a start mark keep adding to the finished query: one with
    // no end mark, then a repeated end mark.
    task automatic test_coordinate_extremes();
        coord_t hi, lo;
        hi = coord_t'(COORD_HI);
        lo = coord_t'(COORD_LO);
        send_beat(make_beat(lo, lo, hi, hi, hi, lo, hi, hi, 1'b1, 1'b0));
        send_beat(make_beat(lo, lo, hi, hi, hi, hi, lo, hi, 1'b0, 1'b1));
        send_beat(make_beat(0, 0, 0, 1, lo, hi, hi, hi, 1'b1, 1'b1));
        send_beat(make_beat(hi, lo, lo, hi, lo, lo, hi, lo, 1'b0, 1'b0));
        send_beat(make_beat(hi, lo, lo, hi, lo, lo, hi, hi, 1'b0, 1'b1));
        send_beat(make_beat(hi, lo, lo, hi, lo, lo, hi, hi, 1'b1, 1'b1));
    endtask

    // Mostly well-formed polygons with random content; about one turn in
    // seven is a burst of fully random beats.
    task automatic test_random_polygons();
        int k;
        while (beats_sent < RANDOM_END) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 6) == 0) begin
                for (k = 0; k < $urandom_range(1, 4); k++) send_beat(random_beat());
            end else begin
                send_random_polygon();
            end
        end
        tx_idle_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while single-edge queries
    // keep coming, so the result register fills and the block stalls its
    // input until the receiver lets go.
    task automatic test_output_hold_off();
        edge_beat_t b;
        int         k;
        rx_hold_req = 1'b1;
        for (k = 0; k < HOLD_BEATS; k++) begin
            b            = random_beat();
            b.first_edge = 1'b1;
            b.last_edge  = 1'b1;
            send_beat(b);
        end
    endtask

    // Last stretch at full speed: no gaps on either side.
    task automatic test_full_rate_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        while (beats_sent < STREAM_END) send_random_polygon();
    endtask

    // Receiver: random stall bursts, calm stretches in which no new burst
    // starts, and the long hold-off when one is requested.
    initial begin : verdict_sink
        int  stall_left;
        int  hold_left;
        int  calm_left;
        bit  calm;
        stall_left = 0;
        hold_left  = 0;
        calm_left  = 0;
        calm       = 1'b0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(20, 200);
            end else begin
                calm_left--;
            end
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (rx_idle_on && !calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Every verdict the block hands over is matched against the oldest one
    // still owed.
    always @(posedge i_clk) begin : verdict_check
        bit want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict %0b with none owed", o_segment_clear));
            end else begin
                want = verdicts_due.pop_front();
                if (o_segment_clear !== want)
                    report_mismatch($sformatf("segment_clear %b, predicted %0b",
                                              o_segment_clear, want));
            end
        end
    end

    // Watchdog: too many cycles with no beat moving on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_seg_start_x = '0;
        i_seg_start_y = '0;
        i_seg_end_x   = '0;
        i_seg_end_y   = '0;
        i_edge_from_x = '0;
        i_edge_from_y = '0;
        i_edge_to_x   = '0;
        i_edge_to_y   = '0;
        i_first_edge  = 1'b0;
        i_last_edge   = 1'b0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        rx_hold_req   = 1'b0;

        // Reset state of the predictor matches the block's reset.
        held_x0   = '0;
        held_y0   = '0;
        held_x1   = '0;
        held_y1   = '0;
        t_enter   = 0;
        t_leave   = int'(T_ONE);
        seg_clear = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edges_without_start();
        test_square_queries();
        test_parallel_edges();
        test_degenerate_input();
        test_coordinate_extremes();
        test_random_polygons();
        test_output_hold_off();
        test_full_rate_stream();

        @(negedge i_clk);
        i_valid <= 1'b0;

        // The watchdog covers a verdict that never comes.
        while (verdicts_due.size() != 0) @(posedge i_clk);
        // Give any stray verdict time to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
hdl/cbclip_pkg.sv
hdl/cbclip_det.sv
hdl/cbclip_div.sv
hdl/segment_convex_polygon_clip_test.sv
verif/segment_convex_polygon_clip_test_test.sv
